// ===== sv/cursor_sequence_table_top_assert.svh =====
// assertion macros for the cursor sequence table
// each macro expects clk and rst_n in scope
`ifndef CURSOR_SEQUENCE_TABLE_TOP_ASSERT_SVH
`define CURSOR_SEQUENCE_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define CST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg
// shared types, codes and field widths of the cursor sequence table
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

    // transaction field widths
    localparam int FUNC_W   = 4;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 5;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;
    localparam int CURSOR_W = 5;

    // default geometry
    localparam int DEPTH_DEF     = 32;
    localparam int WORD_BITS_DEF = 32;

    typedef enum logic [FUNC_W-1:0] {
        OP_START       = 4'd0,
        OP_END         = 4'd1,
        OP_ADVANCE     = 4'd2,
        OP_RETREAT     = 4'd3,
        OP_INSERT      = 4'd4,
        OP_ATTACH      = 4'd5,
        OP_REMOVE      = 4'd6,
        OP_PUSH_FRONT  = 4'd7,
        OP_PUSH_BACK   = 4'd8,
        OP_POP_FRONT   = 4'd9,
        OP_READ_INDEX  = 4'd10
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_NOITEM = 2'd2,
        ST_BADIDX = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE  = 3'd0,
        FSM_SHIFT = 3'd1,
        FSM_PUT   = 3'd2,
        FSM_LOOK  = 3'd3,
        FSM_DONE  = 3'd4
    } fsm_t;

endpackage

`default_nettype wire

// ===== sv/cst_if.sv =====
// ----------------------------------------------------------------------------
// cst_req_if / cst_rsp_if
// valid/ready channels carrying request and response transactions
// ----------------------------------------------------------------------------
`default_nettype none

interface cst_req_if;
    import cst_pkg::*;

    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;

    modport source (output valid, output func, output value, output index, input ready);
    modport sink   (input valid, input func, input value, input index, output ready);
endinterface

interface cst_rsp_if;
    import cst_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [CURSOR_W-1:0] cursor;
    logic                has_item;
    logic [VALUE_W-1:0]  read_value;

    modport source (output valid, output status, output count, output cursor,
                    output has_item, output read_value, input ready);
    modport sink   (input valid, input status, input count, input cursor,
                    input has_item, input read_value, output ready);
endinterface

`default_nettype wire

// ===== sv/cursor_sequence_table_top.sv =====
// Cursor sequence table: an ordered store of up to DEPTH words of WORD_BITS
// bits with a cursor, held in one synchronous memory (one write port, one
// read port, registered read data). Each request transaction carries one
// operation and yields exactly one response transaction. The block works on
// one request at a time: ready is high only while the sequencer is idle. A
// request that moves no stored entries passes through the put, look and done
// states, and its response is loaded into the output register from done;
// insert, push front, attach, remove and pop front first move the later
// entries one per cycle through the memory in the shift state. The
// sequencer goes back to idle as the response is loaded. The response sits
// in an output register, and the next request is accepted while it waits to
// be taken; a further response only waits if that register is still occupied.
// Memory contents are undefined after reset and need no clearing pass, since
// only entries below the count are ever read.
// ----------------------------------------------------------------------------
// cursor_sequence_table_top
// ordered word store with cursor, memory-based shifting sequencer
// ----------------------------------------------------------------------------
`default_nettype none

`include "cursor_sequence_table_top_assert.svh"

module cursor_sequence_table_top #(
    parameter int DEPTH     = cst_pkg::DEPTH_DEF,
    parameter int WORD_BITS = cst_pkg::WORD_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cst_req_if.sink    req,
    cst_rsp_if.source  rsp
);
    import cst_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    // entry store
    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    // architectural state: count and cursor
    logic [CNT_W-1:0] held_reg, held_next;
    logic [PTR_W-1:0] pos_reg,  pos_next;

    fsm_t state_reg, state_next;

    // shift engine
    logic [CNT_W-1:0] rem_reg,       rem_next;
    logic [PTR_W-1:0] rd_ptr_reg,    rd_ptr_next;
    logic             close_reg,     close_next;
    logic             pend_reg,      pend_next;
    logic [PTR_W-1:0] pend_addr_reg, pend_addr_next;

    // final write of the new word and the lookup for the response
    logic                 put_en_reg,    put_en_next;
    logic [PTR_W-1:0]     put_addr_reg,  put_addr_next;
    logic [WORD_BITS-1:0] word_reg,      word_next;
    logic                 look_en_reg,   look_en_next;
    logic [PTR_W-1:0]     look_addr_reg, look_addr_next;
    status_t              status_reg,    status_next;

    // response register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [CURSOR_W-1:0] out_cursor_reg;
    logic                out_item_reg;
    logic [VALUE_W-1:0]  out_rd_reg;

    // memory port controls
    logic                 mem_we;
    logic [PTR_W-1:0]     mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [PTR_W-1:0]     mem_raddr;

    logic in_fire;
    logic out_load;

    // decoded request
    status_t          dec_status;
    logic [CNT_W-1:0] dec_held;
    logic [PTR_W-1:0] dec_pos;
    logic [CNT_W-1:0] dec_copies;
    logic [PTR_W-1:0] dec_start;
    logic             dec_close;
    logic             dec_put;
    logic [PTR_W-1:0] dec_put_addr;
    logic             dec_look;
    logic [PTR_W-1:0] dec_look_addr;

    assign in_fire = req.valid && req.ready;

    // ------------------------------------------------------------------------
    // request decode against the current count and cursor
    // ------------------------------------------------------------------------
    always_comb
    begin
        logic [CNT_W-1:0] pos_ext;
        logic [CNT_W-1:0] held_m1;
        logic [CNT_W-1:0] q;
        logic             full;
        logic             item;
        logic             by_index;
        logic             bad;

        pos_ext  = CNT_W'(pos_reg);
        held_m1  = held_reg - CNT_W'(1);
        full     = held_reg >= CNT_W'(DEPTH);
        item     = pos_ext < held_reg;
        q        = '0;
        by_index = 1'b0;
        bad      = 1'b0;

        dec_status   = ST_OK;
        dec_held     = held_reg;
        dec_pos      = pos_reg;
        dec_copies   = '0;
        dec_start    = PTR_W'(held_m1);
        dec_close    = 1'b0;
        dec_put      = 1'b0;
        dec_put_addr = '0;

        case (op_t'(req.func))
            OP_START:
            begin
                dec_pos = '0;
            end
            OP_END:
            begin
                dec_pos = (held_reg != '0) ? PTR_W'(held_m1) : '0;
            end
            OP_ADVANCE:
            begin
                if (!item)
                    dec_status = ST_NOITEM;
                else if (pos_reg != PTR_W'(DEPTH - 1))
                    dec_pos = pos_reg + PTR_W'(1);
            end
            OP_RETREAT:
            begin
                if (pos_reg != '0)
                    dec_pos = pos_reg - PTR_W'(1);
            end
            OP_INSERT, OP_PUSH_FRONT:
            begin
                if (full)
                    dec_status = ST_FULL;
                else
                begin
                    q = (op_t'(req.func) == OP_PUSH_FRONT || held_reg == '0) ? '0 : pos_ext;
                    if (q > held_reg)
                        q = held_reg;
                    dec_copies   = held_reg - q;
                    dec_put      = 1'b1;
                    dec_put_addr = PTR_W'(q);
                    dec_pos      = PTR_W'(q);
                    dec_held     = held_reg + CNT_W'(1);
                end
            end
            OP_ATTACH:
            begin
                if (full)
                    dec_status = ST_FULL;
                else
                begin
                    dec_put = 1'b1;
                    if (!item)
                    begin
                        dec_put_addr = PTR_W'(held_reg);
                        dec_pos      = PTR_W'(held_reg);
                    end
                    else
                    begin
                        // open a gap just after the cursor
                        dec_copies   = held_m1 - pos_ext;
                        dec_put_addr = pos_reg + PTR_W'(1);
                        dec_pos      = pos_reg + PTR_W'(1);
                    end
                    dec_held = held_reg + CNT_W'(1);
                end
            end
            OP_REMOVE:
            begin
                if (!item)
                    dec_status = ST_NOITEM;
                else
                begin
                    dec_copies = held_m1 - pos_ext;
                    dec_start  = pos_reg + PTR_W'(1);
                    dec_close  = 1'b1;
                    dec_held   = held_m1;
                end
            end
            OP_PUSH_BACK:
            begin
                if (full)
                    dec_status = ST_FULL;
                else
                begin
                    dec_put      = 1'b1;
                    dec_put_addr = PTR_W'(held_reg);
                    dec_pos      = PTR_W'(held_reg);
                    dec_held     = held_reg + CNT_W'(1);
                end
            end
            OP_POP_FRONT:
            begin
                if (held_reg == '0)
                    dec_status = ST_NOITEM;
                else
                begin
                    dec_pos    = '0;
                    dec_copies = held_m1;
                    dec_start  = PTR_W'(1);
                    dec_close  = 1'b1;
                    dec_held   = held_m1;
                end
            end
            OP_READ_INDEX:
            begin
                by_index = 1'b1;
                if (CMP_W'(req.index) >= CMP_W'(held_reg))
                begin
                    bad        = 1'b1;
                    dec_status = ST_BADIDX;
                end
            end
            default:
            begin
                dec_status = ST_OK;
            end
        endcase

        // the response reads either the indexed entry or the entry under the cursor
        if (by_index)
        begin
            dec_look      = !bad;
            dec_look_addr = PTR_W'(req.index);
        end
        else
        begin
            dec_look      = CNT_W'(dec_pos) < dec_held;
            dec_look_addr = dec_pos;
        end
    end

    // ------------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (in_fire)
                    state_next = (dec_copies != '0) ? FSM_SHIFT : FSM_PUT;
            end
            FSM_SHIFT:
            begin
                // the cycle with nothing left to read writes the last moved entry
                if (rem_reg == '0)
                    state_next = FSM_PUT;
            end
            FSM_PUT:
            begin
                state_next = FSM_LOOK;
            end
            FSM_LOOK:
            begin
                state_next = FSM_DONE;
            end
            FSM_DONE:
            begin
                if (out_load)
                    state_next = FSM_IDLE;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // sequencer: outputs (handshake and memory port controls)
    // ------------------------------------------------------------------------
    always_comb
    begin
        req.ready = 1'b0;
        out_load  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = pend_addr_reg;
        mem_wdata = rd_data_reg;
        mem_re    = 1'b0;
        mem_raddr = rd_ptr_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                req.ready = 1'b1;
            end
            FSM_SHIFT:
            begin
                // read one entry ahead, write the previous one a slot along
                mem_re = rem_reg != '0;
                mem_we = pend_reg;
            end
            FSM_PUT:
            begin
                mem_we    = put_en_reg;
                mem_waddr = put_addr_reg;
                mem_wdata = word_reg;
            end
            FSM_LOOK:
            begin
                mem_re    = look_en_reg;
                mem_raddr = look_addr_reg;
            end
            FSM_DONE:
            begin
                out_load = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // datapath next values
    // ------------------------------------------------------------------------
    always_comb
    begin
        held_next      = held_reg;
        pos_next       = pos_reg;
        rem_next       = rem_reg;
        rd_ptr_next    = rd_ptr_reg;
        close_next     = close_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        put_en_next    = put_en_reg;
        put_addr_next  = put_addr_reg;
        word_next      = word_reg;
        look_en_next   = look_en_reg;
        look_addr_next = look_addr_reg;
        status_next    = status_reg;

        if (in_fire)
        begin
            held_next      = dec_held;
            pos_next       = dec_pos;
            rem_next       = dec_copies;
            rd_ptr_next    = dec_start;
            close_next     = dec_close;
            pend_next      = 1'b0;
            put_en_next    = dec_put;
            put_addr_next  = dec_put_addr;
            word_next      = WORD_BITS'(req.value);
            look_en_next   = dec_look;
            look_addr_next = dec_look_addr;
            status_next    = dec_status;
        end
        else if (state_reg == FSM_SHIFT)
        begin
            pend_next = rem_reg != '0;
            if (rem_reg != '0)
            begin
                rem_next       = rem_reg - CNT_W'(1);
                rd_ptr_next    = close_reg ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg - PTR_W'(1);
                pend_addr_next = close_reg ? rd_ptr_reg - PTR_W'(1) : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // response register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            held_reg      <= '0;
            pos_reg       <= '0;
            rem_reg       <= '0;
            pend_reg      <= 1'b0;
            put_en_reg    <= 1'b0;
            look_en_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            pos_reg       <= pos_next;
            rem_reg       <= rem_next;
            pend_reg      <= pend_next;
            put_en_reg    <= put_en_next;
            look_en_reg   <= look_en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        rd_ptr_reg    <= rd_ptr_next;
        close_reg     <= close_next;
        pend_addr_reg <= pend_addr_next;
        put_addr_reg  <= put_addr_next;
        word_reg      <= word_next;
        look_addr_reg <= look_addr_next;
        status_reg    <= status_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_count_reg  <= COUNT_W'(held_reg);
            out_cursor_reg <= CURSOR_W'(pos_reg);
            out_item_reg   <= CNT_W'(pos_reg) < held_reg;
            out_rd_reg     <= look_en_reg ? VALUE_W'(rd_data_reg) : '0;
        end
    end

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.count      = out_count_reg;
    assign rsp.cursor     = out_cursor_reg;
    assign rsp.has_item   = out_item_reg;
    assign rsp.read_value = out_rd_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `CST_ASSERT_NOW(a_cursor_in_range, 1'b1, CNT_W'(pos_reg) <= held_reg,
        "cursor beyond count")
    `CST_ASSERT_NOW(a_count_in_range, 1'b1, held_reg <= CNT_W'(DEPTH),
        "count beyond capacity")
    `CST_ASSERT_NOW(a_no_port_clash, mem_we && mem_re, mem_waddr != mem_raddr,
        "write and read of the same entry in one cycle")
    `CST_ASSERT_NEXT(a_busy_after_accept, in_fire, state_reg != FSM_IDLE,
        "sequencer idle right after accepting a request")

endmodule

`default_nettype wire

// ===== sim/cursor_sequence_table_top_test.sv =====
// ----------------------------------------------------------------------------
// cursor_sequence_table_top_test
// self-checking bench for the cursor sequence table: a directed opening
// covering the empty and edge-of-range cases, then full-store and random
// grow / shrink / walk scenarios with random idling on both channels and one
// long response hold-off. Every response is checked field by field against
// a behavioural model of the ordered store kept inside the bench
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_sequence_table_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cst_pkg::*;

    localparam int TABLE_DEPTH  = DEPTH_DEF;
    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1200;
    // no idling once the backlog falls below this many transactions
    localparam int CALM_TAIL    = 150;
    // a request may shift the whole store, leave some margin
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 40;
    localparam int CYCLE_LIMIT  = 500000;
    // long response hold-off window, counted from time zero
    localparam int HOLD_START   = 3000;
    localparam int HOLD_LEN     = 300;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
    } table_cmd_t;

    typedef struct packed {
        status_t             status;
        logic [COUNT_W-1:0]  count;
        logic [CURSOR_W-1:0] cursor;
        logic                has_item;
        logic [VALUE_W-1:0]  read_value;
    } table_reply_t;

    logic clk;
    logic rst_n;

    cst_req_if req_ch ();
    cst_rsp_if rsp_ch ();

    cursor_sequence_table_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    table_cmd_t   cmd_backlog [$];     // transactions still to be offered
    table_reply_t replies_due [$];     // predicted responses, oldest first

    // mirror of the store: words, count and cursor
    logic [VALUE_W-1:0] mirror_words [TABLE_DEPTH];
    int unsigned        mirror_count;
    int unsigned        mirror_cursor;

    int unsigned planned_items;        // working transactions queued so far
    int unsigned mismatches;
    int unsigned cycle_count;

    // sender side
    table_cmd_t  next_cmd;
    int unsigned send_gap;
    bit          send_jitter;
    bit          calm;                 // last part of the run, no idling at all

    // receiver side
    int unsigned sink_stall;
    bit          sink_jitter;
    bit          hold_off;
    int unsigned hold_clock;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // mismatch reporting: one line per problem, every one counted
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch @ %0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // store model: applies one operation to the mirror and returns the
    // response it should produce
    // ------------------------------------------------------------------------
    function automatic table_reply_t apply_op(input logic [FUNC_W-1:0] code,
                                              input logic [VALUE_W-1:0] word,
                                              input logic [INDEX_W-1:0] idx);
        table_reply_t reply;
        bit           full;
        bit           on_item;
        bit           by_index;
        int unsigned  i;

        reply.status     = ST_OK;
        reply.read_value = '0;
        full     = (mirror_count >= TABLE_DEPTH);
        on_item  = (mirror_cursor < mirror_count);
        by_index = 1'b0;

        case (code)
            OP_START:
            begin
                mirror_cursor = 0;
            end
            OP_END:
            begin
                mirror_cursor = (mirror_count != 0) ? mirror_count - 1 : 0;
            end
            OP_ADVANCE:
            begin
                // cursor sticks at the last slot
                if (!on_item)
                    reply.status = ST_NOITEM;
                else if (mirror_cursor != TABLE_DEPTH - 1)
                    mirror_cursor++;
            end
            OP_RETREAT:
            begin
                if (mirror_cursor != 0)
                    mirror_cursor--;
            end
            OP_INSERT, OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    reply.status = ST_FULL;
                end
                else
                begin
                    if (code == OP_PUSH_FRONT || mirror_count == 0)
                        mirror_cursor = 0;
                    if (mirror_cursor > mirror_count)
                        mirror_cursor = mirror_count;
                    for (i = mirror_count; i > mirror_cursor; i--)
                        mirror_words[i] = mirror_words[i-1];
                    mirror_words[mirror_cursor] = word;
                    mirror_count++;
                end
            end
            OP_ATTACH:
            begin
                if (full)
                begin
                    reply.status = ST_FULL;
                end
                else
                begin
                    // off the end (or empty): append and land on it
                    if (!on_item)
                    begin
                        mirror_cursor = mirror_count;
                    end
                    else
                    begin
                        for (i = mirror_count; i > mirror_cursor + 1; i--)
                            mirror_words[i] = mirror_words[i-1];
                        mirror_cursor++;
                    end
                    mirror_words[mirror_cursor] = word;
                    mirror_count++;
                end
            end
            OP_REMOVE:
            begin
                if (!on_item)
                begin
                    reply.status = ST_NOITEM;
                end
                else
                begin
                    for (i = mirror_cursor + 1; i < mirror_count; i++)
                        mirror_words[i-1] = mirror_words[i];
                    mirror_count--;
                end
            end
            OP_PUSH_BACK:
            begin
                if (full)
                begin
                    reply.status = ST_FULL;
                end
                else
                begin
                    mirror_cursor = mirror_count;
                    mirror_words[mirror_cursor] = word;
                    mirror_count++;
                end
            end
            OP_POP_FRONT:
            begin
                if (mirror_count == 0)
                begin
                    reply.status = ST_NOITEM;
                end
                else
                begin
                    mirror_cursor = 0;
                    for (i = 1; i < mirror_count; i++)
                        mirror_words[i-1] = mirror_words[i];
                    mirror_count--;
                end
            end
            OP_READ_INDEX:
            begin
                by_index = 1'b1;
                if (idx >= mirror_count)
                    reply.status = ST_BADIDX;
                else
                    reply.read_value = mirror_words[idx];
            end
            default:
            begin
                // unused codes leave everything alone
            end
        endcase

        on_item = (mirror_cursor < mirror_count);
        if (!by_index && on_item)
            reply.read_value = mirror_words[mirror_cursor];

        reply.count    = COUNT_W'(mirror_count);
        reply.cursor   = CURSOR_W'(mirror_cursor);
        reply.has_item = on_item;
        return reply;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------------
    task automatic add_cmd(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v,
                           input logic [INDEX_W-1:0] i);
        table_cmd_t c;

        c.func  = f;
        c.value = v;
        c.index = i;
        cmd_backlog.push_back(c);
        // unused codes do nothing, so they do not count as real work
        if (f <= OP_READ_INDEX)
            planned_items++;
    endtask

    // random word and index, so every payload bit toggles
    task automatic add_op(input op_t op);
        add_cmd(op, $urandom, INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)));
    endtask

    function automatic op_t pick_grow();
        case ($urandom_range(0, 3))
            0:       return OP_INSERT;
            1:       return OP_ATTACH;
            2:       return OP_PUSH_FRONT;
            default: return OP_PUSH_BACK;
        endcase
    endfunction

    function automatic op_t pick_move();
        case ($urandom_range(0, 4))
            0:       return OP_START;
            1:       return OP_END;
            2:       return OP_ADVANCE;
            3:       return OP_RETREAT;
            default: return OP_READ_INDEX;
        endcase
    endfunction

    // from any state: fill up, poke at the full store, step back off it
    task automatic add_full_tour();
        int unsigned k;

        add_op(OP_START);
        for (k = 0; k < TABLE_DEPTH + 2; k++)
            add_op(OP_PUSH_BACK);
        add_op(OP_END);
        add_op(OP_ADVANCE);                // sticks at the last slot
        add_op(OP_ADVANCE);
        add_cmd(OP_READ_INDEX, $urandom, INDEX_W'(TABLE_DEPTH - 1));
        add_op(OP_INSERT);
        add_op(OP_ATTACH);
        add_op(OP_PUSH_FRONT);
        add_op(OP_PUSH_BACK);
        add_op(OP_RETREAT);
        add_op(OP_REMOVE);
        add_op(OP_ATTACH);
        add_op(OP_START);
        add_op(OP_POP_FRONT);
    endtask

    task automatic build_stimulus();
        int unsigned n;
        int unsigned k;
        bit          first;

        // directed opening: empty store first
        add_cmd(OP_READ_INDEX, '0, '1);    // beyond count on an empty store
        add_op(OP_ADVANCE);
        add_op(OP_REMOVE);
        add_op(OP_POP_FRONT);
        add_op(OP_END);
        add_op(OP_RETREAT);
        add_cmd(OP_INSERT, '1, '0);        // insert into empty lands at 0
        add_op(OP_POP_FRONT);
        add_cmd(OP_ATTACH, '0, '1);        // attach into empty lands at 0
        add_cmd(OP_PUSH_FRONT, 32'hA5A5_A5A5, '0);
        add_op(OP_ADVANCE);
        add_cmd(OP_PUSH_BACK, 32'h5A5A_5A5A, '0);
        add_op(OP_ADVANCE);                // steps off the end
        add_cmd(OP_ATTACH, 32'h1234_5678, '0);   // no current item: append
        add_op(OP_START);
        add_op(OP_RETREAT);                // retreat at zero
        add_cmd(OP_INSERT, 32'h0F0F_0F0F, '0);
        add_cmd(OP_ATTACH, 32'hF0F0_F0F0, '0);
        add_cmd(OP_READ_INDEX, '0, '0);
        add_cmd(OP_READ_INDEX, '0, INDEX_W'(5));
        add_cmd(OP_READ_INDEX, '0, INDEX_W'(6));
        add_op(OP_REMOVE);
        add_cmd(4'hF, '1, '1);
        add_cmd(4'hB, '0, '0);
        add_op(OP_END);

        // random scenarios; the first pass always takes the store to full
        first = 1'b1;
        planned_items = 0;
        while (planned_items < RANDOM_ITEMS)
        begin
            case (first ? 5 : $urandom_range(0, 9))
                0, 1, 2:
                begin
                    // growth with cursor moves mixed in
                    n = $urandom_range(4, TABLE_DEPTH + 8);
                    for (k = 0; k < n; k++)
                    begin
                        if ($urandom_range(0, 3) == 0)
                            add_op(pick_move());
                        add_op(pick_grow());
                    end
                end
                3, 4:
                begin
                    // shrinking
                    n = $urandom_range(4, TABLE_DEPTH + 8);
                    for (k = 0; k < n; k++)
                    begin
                        case ($urandom_range(0, 5))
                            0, 1, 2: add_op(OP_POP_FRONT);
                            3, 4:    add_op(OP_REMOVE);
                            default: add_op(pick_move());
                        endcase
                    end
                end
                5:
                begin
                    add_full_tour();
                end
                6:
                begin
                    // walk along the store reading and editing
                    add_op(OP_START);
                    n = $urandom_range(3, 20);
                    for (k = 0; k < n; k++)
                    begin
                        case ($urandom_range(0, 7))
                            0:       add_op(OP_READ_INDEX);
                            1:       add_op(OP_RETREAT);
                            2:       add_op(OP_REMOVE);
                            3:       add_op(OP_INSERT);
                            4:       add_op(OP_ATTACH);
                            default: add_op(OP_ADVANCE);
                        endcase
                    end
                end
                7:
                begin
                    // noise: unused codes
                    n = $urandom_range(1, 4);
                    for (k = 0; k < n; k++)
                        add_cmd(FUNC_W'($urandom_range(11, 15)), $urandom,
                                INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)));
                end
                default:
                begin
                    // anything at all, every code including unused ones
                    for (k = 0; k < 10; k++)
                        add_cmd(FUNC_W'($urandom_range(0, 15)), $urandom,
                                INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)));
                end
            endcase
            first = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // request driver: offers the backlog, predicts on acceptance, idles in
    // random bursts; valid is only ever lowered after a transaction goes
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                replies_due.push_back(apply_op(req_ch.func, req_ch.value, req_ch.index));
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    next_cmd = cmd_backlog.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.func  <= next_cmd.func;
                    req_ch.value <= next_cmd.value;
                    req_ch.index <= next_cmd.index;
                    if (cmd_backlog.size() < CALM_TAIL)
                        calm = 1'b1;
                    // alternate stretches with and without idling
                    if ($urandom_range(0, 39) == 0)
                        send_jitter = !send_jitter;
                    if (!calm && send_jitter && $urandom_range(0, 4) == 0)
                        send_gap = $urandom_range(1, 15);
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // response monitor and checker
    // ------------------------------------------------------------------------
    task automatic check_reply();
        table_reply_t got;
        table_reply_t want;

        got.status     = status_t'(rsp_ch.status);
        got.count      = rsp_ch.count;
        got.cursor     = rsp_ch.cursor;
        got.has_item   = rsp_ch.has_item;
        got.read_value = rsp_ch.read_value;

        if (replies_due.size() == 0)
        begin
            report_mismatch($sformatf("response with nothing due: status %0d count %0d",
                                      got.status, got.count));
        end
        else
        begin
            want = replies_due.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status got %0d want %0d",
                                          got.status, want.status));
            if (got.count !== want.count)
                report_mismatch($sformatf("count got %0d want %0d",
                                          got.count, want.count));
            if (got.cursor !== want.cursor)
                report_mismatch($sformatf("cursor got %0d want %0d",
                                          got.cursor, want.cursor));
            if (got.has_item !== want.has_item)
                report_mismatch($sformatf("has_item got %0b want %0b",
                                          got.has_item, want.has_item));
            if (got.read_value !== want.read_value)
                report_mismatch($sformatf("read_value got %08h want %08h",
                                          got.read_value, want.read_value));
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                check_reply();
            if ($urandom_range(0, 59) == 0)
                sink_jitter = !sink_jitter;
            if (hold_off)
            begin
                rsp_ch.ready <= 1'b0;
            end
            else if (sink_stall != 0)
            begin
                sink_stall--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!calm && sink_jitter && $urandom_range(0, 7) == 0)
            begin
                sink_stall = $urandom_range(0, 14);
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // long hold-off on the response side: the output register fills, then
    // the block stops taking requests while the driver keeps offering
    always @(posedge clk)
    begin
        hold_clock++;
        hold_off <= (hold_clock >= HOLD_START) && (hold_clock < HOLD_START + HOLD_LEN);
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence: reset, stimulus, drain, verdict
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.func   = '0;
        req_ch.value  = '0;
        req_ch.index  = '0;
        rsp_ch.ready  = 1'b0;
        mirror_count  = 0;
        mirror_cursor = 0;
        mismatches    = 0;
        send_gap      = 0;
        send_jitter   = 1'b1;
        calm          = 1'b0;
        sink_stall    = 0;
        sink_jitter   = 1'b1;
        hold_off      = 1'b0;
        hold_clock    = 0;

        build_stimulus();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // sample away from the active edge so the queues are settled
        do
        begin
            @(negedge clk);
        end
        while (cmd_backlog.size() != 0 || req_ch.valid || replies_due.size() != 0);

        // catch any stray response after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
